// ===== rtl/mslim_pkg.sv =====
`default_nettype none
package mslim_pkg;

	localparam int CMD_W   = 16;
	localparam int CUR_W   = 14;
	localparam int GAIN_W  = 16;
	localparam int STEP_W  = CMD_W - 1;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;

	// overage is Q.8 amps, gain is Q4.12
	localparam int CUR_FRAC  = 8;
	localparam int GAIN_FRAC = 12;
	localparam int FRAC_SH   = CUR_FRAC + GAIN_FRAC;

	localparam int MA_W   = CUR_W + GAIN_W;
	localparam int MB_W   = (CMD_W > GAIN_W) ? CMD_W : GAIN_W;
	localparam int PROD_W = MA_W + MB_W;
	localparam int CM_W   = PROD_W - FRAC_SH;
	localparam int SUM_W  = CM_W + 2;

	localparam logic [CFG_IDX_W-1:0] REG_OC_THR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLEW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_MAG  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STAT_CUR = 3'd5;

	localparam logic [CUR_W-1:0]  RST_OC_THR   = CUR_W'(7680);
	localparam logic [CUR_W-1:0]  RST_CLIP     = CUR_W'(8960);
	localparam logic [GAIN_W-1:0] RST_GAIN     = '0;
	localparam logic [STEP_W-1:0] RST_SLEW     = STEP_W'(328);
	localparam logic [STEP_W-1:0] RST_MIN_MAG  = STEP_W'(9830);
	localparam logic [CUR_W-1:0]  RST_STAT_CUR = CUR_W'(2560);

	typedef struct packed {
		logic load;
		logic mul_first;
		logic mul_second;
		logic finish;
	} mslim_cmd_t;

	typedef struct packed {
		logic fold;
	} mslim_sts_t;

endpackage
`default_nettype wire

// ===== rtl/mslim_ctrl.sv =====
`default_nettype none
module mslim_ctrl
	import mslim_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire mslim_sts_t sts,
	output mslim_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL1 = 2'd1;
	localparam logic [1:0] S_MUL2 = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load       = accept;
		cmd.mul_first  = (state_q == S_MUL1);
		cmd.mul_second = (state_q == S_MUL2);
		cmd.finish     = (state_q == S_FIN) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = sts.fold ? S_MUL1 : S_FIN;
				end
			end
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_FIN;
			S_FIN: begin
				if (cmd.finish) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input taken while previous beat still in work");

	a_mul_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL2 |-> $past(state_q) == S_MUL1)
		else $error("second product without first");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before taken");

endmodule
`default_nettype wire

// ===== rtl/mslim_dp.sv =====
`default_nettype none
module mslim_dp
	import mslim_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic [CMD_W-1:0]     axis_position,
	input  wire logic [CUR_W-1:0]     current_sample,
	input  wire logic                 run_enable,
	input  wire mslim_cmd_t           cmd,
	output mslim_sts_t                sts,
	output logic [CMD_W-1:0]          drive_command,
	output logic                      high_current_status,
	output logic                      cut_out
);

	localparam logic [CMD_W:0] HALF_P1 = (CMD_W+1)'((1 << (CMD_W - 1)) + 1);
	localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (FRAC_SH - 1);

	// configuration
	logic [CUR_W-1:0]  thr_q;
	logic [CUR_W-1:0]  clip_q;
	logic [GAIN_W-1:0] gain_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] min_q;
	logic [CUR_W-1:0]  stat_q;

	// per-item working registers
	logic [CMD_W-1:0]  mag_q;
	logic [CUR_W-1:0]  over_q;
	logic              run_q;
	logic              ovr_q;
	logic              clip_hit_q;
	logic [PROD_W-1:0] prod_q;

	// state
	logic signed [CMD_W-1:0] last_q;
	logic                    status_q;

	// result register
	logic [CMD_W-1:0] drive_q;
	logic             hcs_q;
	logic             cut_q;

	logic [CMD_W:0]   num;
	logic [CMD_W-1:0] raw_mag;
	logic [CMD_W-1:0] mag_d;
	logic             ovr_d;
	logic             clip_d;

	logic [GAIN_W-1:0] gain_mag;
	logic [MA_W-1:0]   mul_a;
	logic [MB_W-1:0]   mul_b;
	logic [PROD_W-1:0] mul_p;

	logic signed [CMD_W+1:0] target_s;
	logic signed [CMD_W+1:0] last_s;
	logic signed [CMD_W+1:0] diff;
	logic signed [CMD_W+1:0] step_s;
	logic signed [CMD_W+1:0] accel;
	logic signed [CMD_W+1:0] slew_nxt;

	logic [PROD_W-1:0]      rounded;
	logic [CM_W-1:0]        cm;
	logic signed [SUM_W-1:0] corr;
	logic signed [SUM_W-1:0] fsum;
	logic [CMD_W-1:0]       fold_drive;
	logic                   all_zero;
	logic                   all_one;

	logic [CMD_W-1:0] drive_d;
	logic             cut_d;

	// target magnitude = (2^(CW-1) + 1 - z) / 2, raised to the minimum
	always_comb begin
		num     = HALF_P1 - {axis_position[CMD_W-1], axis_position};
		raw_mag = num[CMD_W:1];
		mag_d   = (raw_mag < CMD_W'(min_q)) ? CMD_W'(min_q) : raw_mag;
		ovr_d   = (current_sample >= thr_q);
		clip_d  = (current_sample > clip_q);
		sts.fold = run_enable && ovr_d && !clip_d;
	end

	// shared multiplier: overage*|gain|, then that times |target|
	always_comb begin
		gain_mag = gain_q[GAIN_W-1] ? (~gain_q + GAIN_W'(1)) : gain_q;
		if (cmd.mul_first) begin
			mul_a = MA_W'(over_q);
			mul_b = MB_W'(gain_mag);
		end else begin
			mul_a = prod_q[MA_W-1:0];
			mul_b = MB_W'(mag_q);
		end
		mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// slew path
	always_comb begin
		target_s = -$signed({2'b00, mag_q});
		last_s   = (CMD_W+2)'(last_q);
		diff     = target_s - last_s;
		step_s   = $signed({3'b000, step_q});
		if (diff > step_s) begin
			accel = step_s;
		end else if (diff < -step_s) begin
			accel = -step_s;
		end else begin
			accel = diff;
		end
		slew_nxt = last_s + accel;
	end

	// foldback path: target is always negative, so correction sign follows gain
	always_comb begin
		rounded  = prod_q + RND;
		cm       = rounded[PROD_W-1:FRAC_SH];
		corr     = gain_q[GAIN_W-1] ? $signed({2'b00, cm}) : -$signed({2'b00, cm});
		fsum     = SUM_W'(target_s) + corr;
		all_zero = (fsum[SUM_W-1:CMD_W-1] == '0);
		all_one  = (fsum[SUM_W-1:CMD_W-1] == '1);
		if (all_zero || all_one) begin
			fold_drive = fsum[CMD_W-1:0];
		end else if (fsum[SUM_W-1]) begin
			fold_drive = {1'b1, {(CMD_W-1){1'b0}}};
		end else begin
			fold_drive = {1'b0, {(CMD_W-1){1'b1}}};
		end
	end

	always_comb begin
		drive_d = '0;
		cut_d   = 1'b0;
		if (run_q) begin
			if (ovr_q) begin
				if (clip_hit_q) begin
					cut_d = 1'b1;
				end else begin
					drive_d = fold_drive;
				end
			end else begin
				drive_d = slew_nxt[CMD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= RST_OC_THR;
			clip_q   <= RST_CLIP;
			gain_q   <= RST_GAIN;
			step_q   <= RST_SLEW;
			min_q    <= RST_MIN_MAG;
			stat_q   <= RST_STAT_CUR;
			last_q   <= '0;
			status_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OC_THR:   thr_q  <= cfg_data[CUR_W-1:0];
					REG_CLIP:     clip_q <= cfg_data[CUR_W-1:0];
					REG_GAIN:     gain_q <= cfg_data[GAIN_W-1:0];
					REG_SLEW:     step_q <= cfg_data[STEP_W-1:0];
					REG_MIN_MAG:  min_q  <= cfg_data[STEP_W-1:0];
					REG_STAT_CUR: stat_q <= cfg_data[CUR_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load && run_enable) begin
				status_q <= (current_sample >= stat_q);
			end
			if (cmd.finish && run_q && !ovr_q) begin
				last_q <= $signed(slew_nxt[CMD_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q      <= mag_d;
			over_q     <= current_sample - thr_q;
			run_q      <= run_enable;
			ovr_q      <= ovr_d;
			clip_hit_q <= clip_d;
		end
		if (cmd.mul_first || cmd.mul_second) begin
			prod_q <= mul_p;
		end
		if (cmd.finish) begin
			drive_q <= drive_d;
			hcs_q   <= status_q;
			cut_q   <= cut_d;
		end
	end

	assign drive_command       = drive_q;
	assign high_current_status = hcs_q;
	assign cut_out             = cut_q;

endmodule
`default_nettype wire

// ===== rtl/motor_slew_and_overcurrent_limiter_top.sv =====
`default_nettype none
// Slew-rate limiter with over-current foldback and cut-out. One input beat
// (axis, current, run flag) gives one result beat (drive, status, cut-out).
// The result register is loaded in the finish state, which follows the
// accepting edge directly when no foldback applies; with foldback the item
// first passes the two multiply states: the foldback path runs its two products
// (overage times gain, then times the target magnitude) through one shared
// multiplier in consecutive cycles. The finish state waits while the previous
// result still sits in the output register untaken. The next item is taken as
// soon as the previous result has been loaded into the output register, even
// while that result waits to be taken. Configuration registers come out of
// reset at their default values and may be written whenever the block is idle.
module motor_slew_and_overcurrent_limiter_top
	import mslim_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [CMD_W-1:0]     axis_position,
	input  wire logic [CUR_W-1:0]     current_sample,
	input  wire logic                 run_enable,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [CMD_W-1:0]          drive_command,
	output logic                      high_current_status,
	output logic                      cut_out
);

	mslim_cmd_t cmd;
	mslim_sts_t sts;

	mslim_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mslim_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.axis_position       (axis_position),
		.current_sample      (current_sample),
		.run_enable          (run_enable),
		.cmd                 (cmd),
		.sts                 (sts),
		.drive_command       (drive_command),
		.high_current_status (high_current_status),
		.cut_out             (cut_out)
	);

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
	import mslim_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam logic [CMD_W-1:0] CMD_MIN = {1'b1, {(CMD_W-1){1'b0}}};
	localparam logic [CMD_W-1:0] CMD_MAX = ~CMD_MIN;
	localparam longint HALF = longint'(1) << (CMD_W - 1);

	typedef struct {
		logic [CMD_W-1:0] drive;
		logic status;
		logic cut;
	} drive_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] axis_position = '0;
	logic [CUR_W-1:0] current_sample = '0;
	logic run_enable = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CMD_W-1:0] drive_command;
	logic high_current_status;
	logic cut_out;

	// limiter model: registers and state
	logic [CUR_W-1:0] oc_thr = RST_OC_THR;
	logic [CUR_W-1:0] clip_pt = RST_CLIP;
	logic signed [GAIN_W-1:0] gain = RST_GAIN;
	logic [STEP_W-1:0] slew = RST_SLEW;
	logic [STEP_W-1:0] min_mag = RST_MIN_MAG;
	logic [CUR_W-1:0] stat_cur = RST_STAT_CUR;
	longint last_cmd = 0;
	logic stat_flag = 1'b0;

	drive_result_t drive_expected[$];
	int send_idle = 13;
	int recv_idle = 88;
	int mismatches = 0;
	int results_seen = 0;
	int n_running = 0;
	int n_foldback = 0;
	int n_cutout = 0;
	int n_settings = 0;

	motor_slew_and_overcurrent_limiter_top DUT (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .axis_position, .current_sample, .run_enable,
		.out_valid, .out_ready, .drive_command, .high_current_status, .cut_out
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

	function automatic longint sat_cmd(input longint v);
		if (v > HALF - 1) return HALF - 1;
		if (v < -HALF) return -HALF;
		return v;
	endfunction

	function automatic drive_result_t limit_tick(input logic signed [CMD_W-1:0] z,
			input logic [CUR_W-1:0] amps, input logic run);
		drive_result_t r;
		longint target, mag, minm, f, fm, xm, cm, accel, step, drive;
		logic cut;
		drive = 0;
		cut = 1'b0;
		if (run) begin
			n_running++;
			target = -((HALF - longint'(z) + 1) / 2);
			mag = (target < 0) ? -target : target;
			minm = longint'(min_mag);
			if (mag < minm)
				target = (target <= 0) ? -minm : minm;
			stat_flag = (amps >= stat_cur);
			if (amps >= oc_thr) begin
				if (amps > clip_pt) begin
					cut = 1'b1;
					n_cutout++;
				end else begin
					n_foldback++;
					f = (longint'(amps) - longint'(oc_thr)) * longint'(gain);
					fm = (f < 0) ? -f : f;
					xm = (target < 0) ? -target : target;
					// overage Q.8 times gain Q.12: drop 20 bits, round half away
					cm = (fm * xm + 64'h80000) >> FRAC_SH;
					drive = sat_cmd(target + (((f < 0) != (target < 0)) ? -cm : cm));
				end
			end else begin
				accel = target - last_cmd;
				step = longint'(slew);
				if (accel > step) accel = step;
				if (accel < -step) accel = -step;
				drive = sat_cmd(last_cmd + accel);
				last_cmd = drive;
			end
		end
		r.drive = drive[CMD_W-1:0];
		r.status = stat_flag;
		r.cut = cut;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic send_tick(input logic [CMD_W-1:0] z, input logic [CUR_W-1:0] amps,
			input logic run);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		axis_position <= z;
		current_sample <= amps;
		run_enable <= run;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		drive_expected.push_back(limit_tick(z, amps, run));
	endtask

	// wait for the pipeline to empty before touching registers
	task automatic settle();
		in_valid <= 1'b0;
		while (drive_expected.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
		REG_OC_THR:   oc_thr = data[CUR_W-1:0];
		REG_CLIP:     clip_pt = data[CUR_W-1:0];
		REG_GAIN:     gain = data[GAIN_W-1:0];
		REG_SLEW:     slew = data[STEP_W-1:0];
		REG_MIN_MAG:  min_mag = data[STEP_W-1:0];
		REG_STAT_CUR: stat_cur = data[CUR_W-1:0];
		default: ;
		endcase
	endtask

	task automatic load_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] clip,
			input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] stp,
			input logic [CFG_W-1:0] minm, input logic [CFG_W-1:0] stat);
		set_reg(REG_OC_THR, thr);
		set_reg(REG_CLIP, clip);
		set_reg(REG_GAIN, g);
		set_reg(REG_SLEW, stp);
		set_reg(REG_MIN_MAG, minm);
		set_reg(REG_STAT_CUR, stat);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	function automatic logic [CUR_W-1:0] near_current(input int center);
		int v;
		v = center + int'($urandom_range(0, 8)) - 4;
		if (v < 0) v = 0;
		if (v > (1 << CUR_W) - 1) v = (1 << CUR_W) - 1;
		return CUR_W'(v);
	endfunction

	task automatic test_reset_defaults();
		send_tick('0, '0, 1'b0);
		send_tick(CMD_MAX, '0, 1'b1);
		send_tick(CMD_MIN, CUR_W'(2560), 1'b1);
		send_tick('0, '1, 1'b0);
	endtask

	// bits above each register's width must drop; spare indexes do nothing
	task automatic test_register_widths();
		settle();
		set_reg(REG_SPARE_6, 16'h0000);
		set_reg(REG_SPARE_7, 16'hFFFF);
		load_config(16'hC000 | 16'd300, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'h8000 | 16'd50, 16'hC000 | 16'd10);
		send_tick(CMD_MAX, CUR_W'(100), 1'b1);
		send_tick('0, CUR_W'(300), 1'b1);
		send_tick('0, '1, 1'b1);
	endtask

	task automatic test_foldback_and_cutout();
		settle();
		load_config(16'd1000, 16'd16383, 16'h8000, 16'h7FFF, 16'd0, 16'd16383);
		send_tick('0, CUR_W'(999), 1'b1);
		send_tick(CMD_MAX, CUR_W'(1000), 1'b1);
		send_tick(CMD_MIN, '1, 1'b1);
		send_tick(CMD_MIN, '1, 1'b0);
		settle();
		load_config(16'd0, 16'd16382, 16'h7FFF, 16'd0, 16'h7FFF, 16'd0);
		send_tick(CMD_MAX, '1, 1'b1);
		send_tick('0, CUR_W'(16382), 1'b1);
		send_tick('0, '0, 1'b1);
		// clip point below the foldback threshold
		settle();
		load_config(16'd5000, 16'd3000, 16'h0800, 16'd0, 16'd100, 16'd4000);
		send_tick('0, CUR_W'(3999), 1'b1);
		send_tick('0, CUR_W'(4000), 1'b1);
		send_tick('0, CUR_W'(5000), 1'b1);
		send_tick('0, CUR_W'(4999), 1'b0);
		// correction lands exactly on a half LSB, both signs
		settle();
		load_config(16'd256, 16'd16383, 16'h1000, 16'd328, 16'd0, 16'd2560);
		send_tick(CMD_W'(32000), CUR_W'(257), 1'b1);
		settle();
		load_config(16'd256, 16'd16383, 16'hF000, 16'd328, 16'd0, 16'd2560);
		send_tick(CMD_W'(32000), CUR_W'(257), 1'b1);
	endtask

	task automatic test_random_traffic(input int s_idle, input int r_idle);
		logic [CMD_W-1:0] z;
		logic [CUR_W-1:0] amps;
		logic [CFG_W-1:0] v;
		int i;
		z = '0;
		send_idle = s_idle;
		recv_idle = r_idle;
		repeat (6) begin
			settle();
			for (i = 0; i < (1 << CFG_IDX_W); i++) begin
				case ($urandom_range(0, 7))
				0: v = (i == REG_GAIN) ? 16'h8000 : 16'h0000;
				1: v = (i == REG_GAIN) ? 16'h7FFF : 16'hFFFF;
				2: v = CFG_W'($urandom_range(0, 600));
				default: v = CFG_W'($urandom);
				endcase
				set_reg(CFG_IDX_W'(i), v);
			end
			cfg_we <= 1'b0;
			n_settings++;
			// axis held for stretches so the slew path can converge
			repeat (70) begin
				if ($urandom_range(0, 3) == 0) begin
					case ($urandom_range(0, 5))
					0: z = CMD_MIN;
					1: z = CMD_MAX;
					2: z = CMD_MAX - CMD_W'($urandom_range(0, 2000));
					default: z = CMD_W'($urandom);
					endcase
				end
				case ($urandom_range(0, 5))
				0: amps = near_current(oc_thr);
				1: amps = near_current(clip_pt);
				2: amps = near_current(stat_cur);
				3, 4: amps = CUR_W'($urandom_range(0, oc_thr));
				default: amps = CUR_W'($urandom);
				endcase
				send_tick(z, amps, $urandom_range(0, 9) != 0);
			end
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		drive_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (drive_expected.size() == 0) begin
				report_mismatch($sformatf("beat %0d arrived with no tick outstanding",
					results_seen));
			end else begin
				want = drive_expected.pop_front();
				if (drive_command !== want.drive)
					report_mismatch($sformatf("beat %0d drive_command %0d, want %0d",
						results_seen, $signed(drive_command), $signed(want.drive)));
				if (high_current_status !== want.status)
					report_mismatch($sformatf("beat %0d high_current_status %b, want %b",
						results_seen, high_current_status, want.status));
				if (cut_out !== want.cut)
					report_mismatch($sformatf("beat %0d cut_out %b, want %b",
						results_seen, cut_out, want.cut));
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_widths();
		test_foldback_and_cutout();
		test_random_traffic(13, 88);
		test_random_traffic(88, 13);
		test_random_traffic(0, 0);
		settle();
		if (drive_expected.size() != 0)
			report_mismatch("ticks left without a result");
		$display("tb: %0d beats checked, %0d running ticks, %0d in foldback, %0d cut out",
			results_seen, n_running, n_foldback, n_cutout);
		$display("tb: %0d register settings; stall mixes 13/88, 88/13 and none",
			n_settings);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/mslim_pkg.sv
rtl/mslim_ctrl.sv
rtl/mslim_dp.sv
rtl/motor_slew_and_overcurrent_limiter_top.sv
dv/tb.sv
